### design/kpc_pkg.sv
// Package with shared types and constants for the keyboard port controller.
package kpc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    // Item kinds.
    localparam logic [1:0] OP_BUS_READ  = 2'd0;
    localparam logic [1:0] OP_BUS_WRITE = 2'd1;
    localparam logic [1:0] OP_KEY_EVENT = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    // Port offsets from 0x60.
    localparam logic [2:0] OFF_DATA    = 3'd0;
    localparam logic [2:0] OFF_PORT_B  = 3'd1;
    localparam logic [2:0] OFF_MEM_SW  = 3'd2;
    localparam logic [2:0] OFF_STATUS  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_RAM_SIZE = 1'b0;
    localparam logic CFG_DISPLAY  = 1'b1;

    localparam logic [9:0] RAM_SIZE_RESET = 10'd256;
    localparam logic [7:0] DISPLAY_RESET  = 8'h10;

    localparam logic [7:0] CMD_ID_REQUEST = 8'h05;
    localparam logic [7:0] ID_RESPONSE    = 8'h82;
    localparam logic [7:0] SELF_TEST_OK   = 8'hAA;
    localparam logic [7:0] UNMAPPED_BYTE  = 8'hFF;

    // Port B bit positions.
    localparam int unsigned PB_SPEAKER = 0;
    localparam int unsigned PB_MEM_SEL = 2;
    localparam int unsigned PB_KBD_CLK = 6;
    localparam int unsigned PB_ACK     = 7;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] port_offset;
        logic [7:0] write_data;
        logic       debug_access;
        logic [6:0] key_scan;
        logic       key_pressed;
    } t_kpc_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
        logic       irq_level;
        logic       speaker_gate;
    } t_kpc_out;

    // Commands from the controller to the scan queue.
    typedef struct packed {
        logic       flush;
        logic       push;
        logic [7:0] push_data;
        logic       rd_req;
        logic       pop;
    } t_kpc_qcmd;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] rd_data;
    } t_kpc_qstat;

endpackage

### design/kpc_scan_queue.sv
// Circular scancode queue: one synchronous RAM plus head and tail pointers.
module kpc_scan_queue #(
    parameter int unsigned QUEUE_DEPTH = kpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kpc_pkg::t_kpc_qcmd i_cmd,
    output kpc_pkg::t_kpc_qstat o_stat
);

    localparam int unsigned AW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    logic [7:0]    mem [QUEUE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [AW-1:0] tail_next;
    logic [AW-1:0] head_next;
    logic [AW-1:0] wr_addr;

    assign tail_next = (r_tail == LAST) ? '0 : r_tail + AW'(1);
    assign head_next = (r_head == LAST) ? '0 : r_head + AW'(1);
    // A flush restarts the queue and places its byte in slot zero.
    assign wr_addr   = i_cmd.flush ? '0 : r_tail;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_cmd.flush) begin
            n_head = '0;
            n_tail = AW'(1);
        end else begin
            if (i_cmd.push) begin
                n_tail = tail_next;
            end
            if (i_cmd.pop) begin
                n_head = head_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.flush || i_cmd.push) begin
            mem[wr_addr] <= i_cmd.push_data;
        end
        if (i_cmd.rd_req) begin
            r_rd_data <= mem[r_head];
        end
    end

    assign o_stat.empty   = (r_head == r_tail);
    assign o_stat.full    = (tail_next == r_head);
    assign o_stat.rd_data = r_rd_data;

endmodule

### design/keyboard_port_controller.sv
// Top level of the XT-style keyboard and board-switch port controller.
// A result is registered in the cycle after its input transfer; a tick that delivers
// a key goes through S_FETCH first, since the queue head is read from the scan RAM.
// Throughput: one item per cycle unless the output stalls, except a delivering tick,
// which holds input in S_FETCH while the RAM read completes. Reset is synchronous and
// active low; it clears pointers, latch, port B and flags; the scan RAM is not cleared.
module keyboard_port_controller #(
    parameter int unsigned QUEUE_DEPTH = kpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kpc_pkg::t_kpc_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output kpc_pkg::t_kpc_out o_out_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [9:0]        i_cfg_data
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;

    logic              r_state, n_state;
    logic [9:0]        r_ram_size;
    logic [7:0]        r_display;
    logic [7:0]        r_latch, n_latch;
    logic              r_latch_full, n_latch_full;
    logic [7:0]        r_port_b, n_port_b;
    logic              r_pending, n_pending;
    logic              r_armed, n_armed;
    logic              r_irq, n_irq;
    logic              r_out_valid;
    kpc_pkg::t_kpc_out r_out, n_out;
    logic              produce;
    logic              in_xfer;
    logic [8:0]        mem_code;
    logic [7:0]        mem_x;
    logic [7:0]        switch_byte;
    logic [7:0]        key_byte;
    kpc_pkg::t_kpc_qcmd  q_cmd;
    kpc_pkg::t_kpc_qstat q_stat;

    kpc_scan_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (q_cmd),
        .o_stat (q_stat)
    );

    // Memory size code wraps to all ones below 16 KiB.
    assign mem_code    = {3'b000, r_ram_size[9:4]} - 9'd1;
    assign mem_x       = mem_code[8:1];
    assign switch_byte = r_display | {5'b00000, mem_code[0], 2'b00};
    assign key_byte    = {~i_in_data.key_pressed, i_in_data.key_scan};

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_latch      = r_latch;
        n_latch_full = r_latch_full;
        n_port_b     = r_port_b;
        n_pending    = r_pending;
        n_armed      = r_armed;
        n_irq        = r_irq;
        n_out        = '0;
        produce      = 1'b0;
        q_cmd        = '0;
        if (r_state == S_FETCH) begin
            // The head byte is now out of the RAM.
            q_cmd.pop    = 1'b1;
            n_latch      = q_stat.rd_data;
            n_latch_full = 1'b1;
            n_irq        = 1'b1;
            n_state      = S_IDLE;
            produce      = 1'b1;
        end else if (in_xfer) begin
            produce = 1'b1;
            unique case (i_in_data.op)
                kpc_pkg::OP_BUS_READ: begin
                    unique case (i_in_data.port_offset)
                        kpc_pkg::OFF_DATA: begin
                            if (r_pending) begin
                                n_out.read_data = kpc_pkg::ID_RESPONSE;
                                if (!i_in_data.debug_access) begin
                                    n_pending = 1'b0;
                                end
                            end else if (r_port_b[kpc_pkg::PB_ACK]) begin
                                n_out.read_data = switch_byte;
                            end else begin
                                n_out.read_data = r_latch;
                            end
                        end
                        kpc_pkg::OFF_PORT_B: n_out.read_data = r_port_b;
                        kpc_pkg::OFF_MEM_SW: begin
                            n_out.read_data = r_port_b[kpc_pkg::PB_MEM_SEL]
                                ? {4'h0, mem_x[3:0]} : {4'h0, mem_x[7:4]};
                        end
                        kpc_pkg::OFF_STATUS:
                            n_out.read_data = {7'd0, r_pending || r_latch_full};
                        default: n_out.read_data = kpc_pkg::UNMAPPED_BYTE;
                    endcase
                end
                kpc_pkg::OP_BUS_WRITE: begin
                    if (i_in_data.port_offset == kpc_pkg::OFF_DATA) begin
                        if (i_in_data.write_data == kpc_pkg::CMD_ID_REQUEST) begin
                            n_pending = 1'b1;
                        end
                    end else if (i_in_data.port_offset == kpc_pkg::OFF_PORT_B) begin
                        // Rising keyboard clock enable is the keyboard reset handshake.
                        if (!r_port_b[kpc_pkg::PB_KBD_CLK]
                            && i_in_data.write_data[kpc_pkg::PB_KBD_CLK]) begin
                            q_cmd.flush     = 1'b1;
                            q_cmd.push_data = kpc_pkg::SELF_TEST_OK;
                            n_latch_full    = 1'b0;
                            n_irq           = 1'b0;
                        end
                        if (i_in_data.write_data[kpc_pkg::PB_ACK]) begin
                            n_latch_full = 1'b0;
                            n_irq        = 1'b0;
                        end
                        n_port_b = i_in_data.write_data;
                        if (!r_armed && !n_latch_full
                            && i_in_data.write_data[kpc_pkg::PB_KBD_CLK]
                            && (q_cmd.flush || !q_stat.empty)) begin
                            n_armed = 1'b1;
                        end
                    end
                end
                kpc_pkg::OP_KEY_EVENT: begin
                    if (q_stat.full) begin
                        n_out.status = 1'b1;
                    end else begin
                        q_cmd.push      = 1'b1;
                        q_cmd.push_data = key_byte;
                        if (!r_latch_full && r_port_b[kpc_pkg::PB_KBD_CLK]) begin
                            n_armed = 1'b1;
                        end
                    end
                end
                default: begin
                    if (r_armed) begin
                        n_armed = 1'b0;
                        if (r_port_b[kpc_pkg::PB_KBD_CLK] && !r_latch_full
                            && !q_stat.empty) begin
                            q_cmd.rd_req = 1'b1;
                            n_state      = S_FETCH;
                            produce      = 1'b0;
                        end
                    end
                end
            endcase
        end
        n_out.irq_level    = n_irq;
        n_out.speaker_gate = n_port_b[kpc_pkg::PB_SPEAKER];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ram_size   <= kpc_pkg::RAM_SIZE_RESET;
            r_display    <= kpc_pkg::DISPLAY_RESET;
            r_latch      <= '0;
            r_latch_full <= 1'b0;
            r_port_b     <= '0;
            r_pending    <= 1'b0;
            r_armed      <= 1'b0;
            r_irq        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_latch      <= n_latch;
            r_latch_full <= n_latch_full;
            r_port_b     <= n_port_b;
            r_pending    <= n_pending;
            r_armed      <= n_armed;
            r_irq        <= n_irq;
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    kpc_pkg::CFG_RAM_SIZE: r_ram_size <= i_cfg_data;
                    default:               r_display  <= i_cfg_data[7:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The output register is always free while a queue read is outstanding.
    a_fetch_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> !r_out_valid)
        else $error("result pending during queue fetch");

    a_fetch_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |=> r_state == S_IDLE && r_latch_full && r_out_valid)
        else $error("queue fetch did not complete a delivery");

    a_irq_needs_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq |-> r_latch_full)
        else $error("IRQ1 raised with an empty key latch");

endmodule
